### rtl/sce_pkg.sv
package sce_pkg;

  localparam int BUFFER_SIZE_DEF = 64;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam int DEL_LEN = 20;
  localparam int ESC_LEN = 20;
  localparam int OVF_LEN = 19;

  localparam logic [8*DEL_LEN-1:0] DEL_TEXT = "\nDelete the Command\n";
  localparam logic [8*ESC_LEN-1:0] ESC_TEXT = "\nEscape the Command\n";
  localparam logic [8*OVF_LEN-1:0] OVF_TEXT = "\nCommand Over Flow\n";

  typedef enum logic [2:0] {
    ST_WAIT = 3'd0,
    ST_EXEC = 3'd1,
    ST_DELETED = 3'd2,
    ST_ESCAPED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // What the emitter sends for one item
  typedef enum logic [2:0] {
    MSG_NONE,
    MSG_ECHO,
    MSG_BACKSPACE,
    MSG_NEWLINE,
    MSG_DELETE,
    MSG_ESCAPE,
    MSG_OVERFLOW,
    MSG_READ
  } msg_t;

  typedef struct packed {
    msg_t       msg;
    logic [7:0] echo_byte;
    status_t    status;
    logic       rd_ok;
  } job_t;

  function automatic logic [4:0] msg_len(msg_t m);
    logic [4:0] n;
    unique case (m)
      MSG_BACKSPACE: n = 5'd3;
      MSG_DELETE:    n = 5'(DEL_LEN);
      MSG_ESCAPE:    n = 5'(ESC_LEN);
      MSG_OVERFLOW:  n = 5'(OVF_LEN);
      default:       n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_char(msg_t m, logic [4:0] i);
    logic [7:0] c;
    int k;
    c = 8'h00;
    k = int'(i);
    unique case (m)
      MSG_BACKSPACE: c = (k == 1) ? CH_SP : CH_BS;
      MSG_NEWLINE:   c = CH_LF;
      MSG_DELETE:    if (k < DEL_LEN) c = DEL_TEXT[8*(DEL_LEN-1-k) +: 8];
      MSG_ESCAPE:    if (k < ESC_LEN) c = ESC_TEXT[8*(ESC_LEN-1-k) +: 8];
      MSG_OVERFLOW:  if (k < OVF_LEN) c = OVF_TEXT[8*(OVF_LEN-1-k) +: 8];
      default:       c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/sce_ram.sv
module sce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### rtl/sce_decode.sv
module sce_decode import sce_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF,
  parameter int AW = $clog2(BUFFER_SIZE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          kind,
  input  logic [7:0]    rx_byte,
  input  logic [6:0]    read_index,
  output job_t          job,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr
);

  localparam int IW = (AW > 7) ? AW : 7;

  logic [AW-1:0] cursor_r, cursor_nxt;
  logic [IW-1:0] idx_ext;
  logic          in_range;
  logic          wr;

  assign idx_ext   = IW'(read_index);
  assign in_range  = idx_ext <= IW'(BUFFER_SIZE);
  assign ram_raddr = idx_ext[AW-1:0];
  assign ram_re    = accept && kind && in_range;
  assign ram_waddr = cursor_r;
  assign ram_we    = accept && !kind && wr;

  always_comb begin
    cursor_nxt     = cursor_r;
    wr             = 1'b0;
    ram_wdata      = 8'h00;
    job.msg        = MSG_NONE;
    job.echo_byte  = rx_byte;
    job.status     = ST_WAIT;
    job.rd_ok      = in_range;
    if (kind) begin
      job.msg = MSG_READ;
    end else begin
      unique case (rx_byte)
        CH_NUL, CH_CR: begin
          job.msg = MSG_NONE;
        end
        CH_BS: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - AW'(1);
            job.msg    = MSG_BACKSPACE;
          end
        end
        CH_LF: begin
          // cursor never passes the last slot, so it is the terminator spot
          wr         = 1'b1;
          cursor_nxt = '0;
          job.msg    = MSG_NEWLINE;
          job.status = ST_EXEC;
        end
        CH_DEL: begin
          cursor_nxt = '0;
          job.msg    = MSG_DELETE;
          job.status = ST_DELETED;
        end
        CH_ESC: begin
          cursor_nxt = '0;
          job.msg    = MSG_ESCAPE;
          job.status = ST_ESCAPED;
        end
        default: begin
          if (cursor_r < AW'(BUFFER_SIZE)) begin
            wr         = 1'b1;
            ram_wdata  = rx_byte;
            cursor_nxt = cursor_r + AW'(1);
            job.msg    = MSG_ECHO;
          end else begin
            cursor_nxt = '0;
            job.msg    = MSG_OVERFLOW;
            job.status = ST_OVERFLOW;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (accept && !kind) begin
      cursor_r <= cursor_nxt;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= AW'(BUFFER_SIZE))
    else $error("cursor beyond line store");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read by one word");

  a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !kind && job.msg == MSG_OVERFLOW |=> cursor_r == '0)
    else $error("overflow left cursor set");

endmodule

### rtl/sce_emit.sv
module sce_emit import sce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  job_t       job_in,
  input  logic [7:0] ram_rdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_byte,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last,
  output logic [7:0] out_read_data
);

  logic       job_valid_r;
  job_t       job_r;
  logic [4:0] idx_r;
  logic       advance;
  logic       fin;
  logic       load;
  logic       out_valid_r;
  logic       has_nxt;
  logic [7:0] byte_nxt;
  logic [7:0] rdata_nxt;

  assign advance  = job_valid_r && (!out_valid_r || out_ready);
  assign fin      = idx_r == msg_len(job_r.msg) - 5'd1;
  assign in_ready = !job_valid_r || (advance && fin);
  assign load     = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    has_nxt   = 1'b1;
    byte_nxt  = msg_char(job_r.msg, idx_r);
    rdata_nxt = 8'h00;
    unique case (job_r.msg)
      MSG_NONE: begin
        has_nxt  = 1'b0;
        byte_nxt = 8'h00;
      end
      MSG_READ: begin
        has_nxt   = 1'b0;
        byte_nxt  = 8'h00;
        rdata_nxt = job_r.rd_ok ? ram_rdata : 8'h00;
      end
      MSG_ECHO: byte_nxt = job_r.echo_byte;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (advance) begin
        // hold the job until its final character leaves
        job_valid_r <= !fin;
        idx_r       <= idx_r + 5'd1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
    if (advance) begin
      out_has_byte  <= has_nxt;
      out_byte      <= byte_nxt;
      out_status    <= job_r.status;
      out_last      <= fin;
      out_read_data <= rdata_nxt;
    end
  end

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last |-> job_valid_r)
    else $error("word without last but no job pending");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> idx_r < msg_len(job_r.msg))
    else $error("message index past its end");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> job_valid_r && idx_r == '0)
    else $error("accepted word did not start a job");

endmodule

### rtl/serial_command_line_editor_top.sv
// Channel  Ports                                               Direction
// in       in_valid/in_ready, in_kind, in_rx_byte,             input
//          in_read_index
// out      out_valid/out_ready, out_has_byte, out_byte,        output
//          out_status, out_last, out_read_data
//
// One result word leaves per cycle while out_ready is not stalled. An item
// has as many result words as its message has characters: 1 for most,
// 3 for backspace, 19 or 20 for the messages, made by the message emitter.
// The next item is taken in the cycle its predecessor's last word is issued.
// rst_n clears the cursor and the job and output valid flags; the line store
// is not cleared. A stalled out_ready holds the output word and the job.
module serial_command_line_editor_top import sce_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic [6:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_byte,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last,
  output logic [7:0] out_read_data
);

  localparam int DEPTH = BUFFER_SIZE + 1;
  localparam int AW = $clog2(DEPTH);

  job_t          job;
  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign accept = in_valid && in_ready;

  sce_decode #(
    .BUFFER_SIZE(BUFFER_SIZE),
    .AW(AW)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_kind),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .job        (job),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  sce_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  sce_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .job_in        (job),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_has_byte  (out_has_byte),
    .out_byte      (out_byte),
    .out_status    (out_status),
    .out_last      (out_last),
    .out_read_data (out_read_data)
  );

endmodule
